### src/pq_pkg.sv
package pq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ROT_W    = CNT_W;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_POP = 2'd1;
   localparam logic [1:0] KIND_DEL = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] priority_req;
      logic [15:0]        task_id;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        out_id;
      logic signed [15:0] out_priority;
      logic [4:0]         count;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [15:0]        id;
      logic signed [15:0] prio;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic               keep;
      logic [15:0]        new_id;
      logic signed [15:0] new_prio;
   } cell_ctl_type;

   function automatic logic [4:0] count_field(input logic [CNT_W-1:0] c);
      logic [CNT_W+4:0] w;
      w = {5'b0, c};
      return w[4:0];
   endfunction

endpackage

### src/priority_task_queue.sv
// Add, pop and unused kinds: the result is registered in ST_EXEC once the
// output slot is free. Delete: after ST_EXEC, the held entries rotate
// through the cell row in ST_ROT, one entry per cycle past the head; ST_DONE
// then registers the result once the slot is free. One request in flight.
// Reset (synchronous): empties the queue, ID counter back to 1; no sweep.
module priority_task_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  pq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output pq_pkg::rsp_type rsp_data
);
   import pq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_ROT  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [15:0]        next_id_ff, next_id_in;
   logic [ROT_W-1:0]   rot_left_ff, rot_left_in;
   logic               found_ff, found_in;
   logic signed [15:0] hit_prio_ff, hit_prio_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   cell_ctl_type       ctl;
   entry_type          cell_q [CAPACITY];
   logic               cell_ge [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;
   logic               slot_free;
   logic               hit;

   localparam entry_type ENTRY_TOP  = '{valid: 1'b1, id: 16'd0, prio: 16'sd0};
   localparam entry_type ENTRY_NONE = '{valid: 1'b0, id: 16'd0, prio: 16'sd0};

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         entry_type prev_e, next_e;
         logic      prev_g;
         if (g == 0) begin : g_first
            assign prev_e = ENTRY_TOP;
            assign prev_g = 1'b1;
         end else begin : g_mid
            assign prev_e = cell_q[g-1];
            assign prev_g = cell_ge[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign next_e = ENTRY_NONE;
         end else begin : g_body
            assign next_e = cell_q[g+1];
         end
         pq_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .head    (cell_q[0]),
            .prev    (prev_e),
            .prev_ge (prev_g),
            .next    (next_e),
            .cur     (cell_q[g]),
            .ge      (cell_ge[g])
         );
         assign valid_vec[g] = cell_q[g].valid;
      end
   endgenerate

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign hit       = (cell_q[0].id == req_ff.task_id);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      rot_left_in  = rot_left_ff;
      found_in     = found_ff;
      hit_prio_in  = hit_prio_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctl.op       = OP_HOLD;
      ctl.keep     = 1'b0;
      ctl.new_id   = next_id_ff;
      ctl.new_prio = req_ff.priority_req;
      case (state_ff)
         ST_IDLE: begin
            found_in    = 1'b0;
            rot_left_in = count_ff;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.kind == KIND_DEL) begin
               state_in = ST_ROT;
            end else if (slot_free) begin
               state_in            = ST_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_MISS;
               rsp_in.out_id       = 16'd0;
               rsp_in.out_priority = 16'sd0;
               rsp_in.count        = count_field(count_ff);
               case (req_ff.kind)
                  KIND_ADD: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        ctl.op              = OP_INSERT;
                        count_in            = count_ff + 1'b1;
                        next_id_in          = (next_id_ff == 16'hFFFF) ? 16'd1
                                                                       : next_id_ff + 16'd1;
                        rsp_in.status       = STATUS_OK;
                        rsp_in.out_id       = next_id_ff;
                        rsp_in.out_priority = req_ff.priority_req;
                        rsp_in.count        = count_field(count_in);
                     end
                  end
                  KIND_POP: begin
                     if (count_ff != '0) begin
                        ctl.op              = OP_ROTATE;
                        ctl.keep            = 1'b0;
                        count_in            = count_ff - 1'b1;
                        rsp_in.status       = STATUS_OK;
                        rsp_in.out_id       = cell_q[0].id;
                        rsp_in.out_priority = cell_q[0].prio;
                        rsp_in.count        = count_field(count_in);
                     end
                  end
                  default: begin
                     rsp_in.status = STATUS_MISS;
                  end
               endcase
            end
         end
         ST_ROT: begin
            // head word goes to the tail unless its ID matches
            if (rot_left_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               ctl.op      = OP_ROTATE;
               ctl.keep    = !hit;
               rot_left_in = rot_left_ff - 1'b1;
               if (hit) begin
                  count_in = count_ff - 1'b1;
                  if (!found_ff) begin
                     found_in    = 1'b1;
                     hit_prio_in = cell_q[0].prio;
                  end
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in            = ST_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_in.status       = found_ff ? STATUS_OK : STATUS_MISS;
               rsp_in.out_id       = found_ff ? req_ff.task_id : 16'd0;
               rsp_in.out_priority = found_ff ? hit_prio_ff : 16'sd0;
               rsp_in.count        = count_field(count_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_id_ff   <= 16'd1;
         rot_left_ff  <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         rot_left_ff  <= rot_left_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      hit_prio_ff <= hit_prio_in;
      rsp_ff      <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("held count above capacity");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1}))
      else $error("valid cells not packed from head");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_vec) == int'(count_ff)))
      else $error("count disagrees with valid cells");

   a_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != 16'd0)
      else $error("ID counter reached zero");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted word not taken into execution");

endmodule

### src/pq_cell.sv
module pq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  pq_pkg::cell_ctl_type ctl,
   input  pq_pkg::entry_type    head,
   input  pq_pkg::entry_type    prev,
   input  logic                 prev_ge,
   input  pq_pkg::entry_type    next,
   output pq_pkg::entry_type    cur,
   output logic                 ge
);
   import pq_pkg::*;

   logic               valid_ff, valid_in;
   logic [15:0]        id_ff, id_in;
   logic signed [15:0] prio_ff, prio_in;
   logic               last;

   assign cur.valid = valid_ff;
   assign cur.id    = id_ff;
   assign cur.prio  = prio_ff;

   // held entry that the new one must stay behind (ties keep arrival order)
   assign ge   = valid_ff && (prio_ff >= ctl.new_prio);
   // last held entry: the rotated head word lands here
   assign last = valid_ff && !next.valid;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (!ge) begin
               if (prev_ge) begin
                  valid_in = 1'b1;
                  id_in    = ctl.new_id;
                  prio_in  = ctl.new_prio;
               end else begin
                  valid_in = prev.valid;
                  id_in    = prev.id;
                  prio_in  = prev.prio;
               end
            end
         end
         OP_ROTATE: begin
            if (last) begin
               valid_in = ctl.keep;
               id_in    = head.id;
               prio_in  = head.prio;
            end else begin
               valid_in = next.valid;
               id_in    = next.id;
               prio_in  = next.prio;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

endmodule
